// ===== hdl/gss_pkg.sv =====
package gss_pkg;

    localparam int CELL_W = 24;
    localparam int SUM9_W = 26;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RATE_W = 16;
    localparam int LEN_W = 12;
    localparam int OUT_COL_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIF_U = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIF_V = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN = 3'd4;

    localparam logic [RATE_W-1:0] FEED_RST = 16'd2753;
    localparam logic [RATE_W-1:0] KILL_RST = 16'd3867;
    localparam logic [RATE_W-1:0] DIF_U_RST = 16'd10486;
    localparam logic [RATE_W-1:0] DIF_V_RST = 16'd5243;
    localparam logic [LEN_W-1:0] LEN_RST = 12'd2048;

    typedef struct packed {
        logic signed [SUM9_W-1:0] edges_u;
        logic signed [SUM9_W-1:0] corners_u;
        logic signed [CELL_W-1:0] center_u;
        logic signed [SUM9_W-1:0] edges_v;
        logic signed [SUM9_W-1:0] corners_v;
        logic signed [CELL_W-1:0] center_v;
    } gss_sums_t;

    typedef struct packed {
        logic [RATE_W-1:0] feed;
        logic [RATE_W-1:0] kill;
        logic [RATE_W-1:0] dif_u;
        logic [RATE_W-1:0] dif_v;
    } gss_coef_t;

endpackage

// ===== hdl/gss_cell_if.sv =====
interface gss_cell_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] cell_u;
    logic signed [23:0] cell_v;
    logic               tile_start;

    modport source (output valid, output cell_u, output cell_v, output tile_start,
                    input ready);
    modport sink (input valid, input cell_u, input cell_v, input tile_start,
                  output ready);
endinterface

// ===== hdl/gss_result_if.sv =====
interface gss_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] new_u;
    logic signed [23:0] new_v;
    logic [10:0]        out_column;
    logic               row_done;

    modport source (output valid, output new_u, output new_v, output out_column,
                    output row_done, input ready);
    modport sink (input valid, input new_u, input new_v, input out_column,
                  input row_done, output ready);
endinterface

// ===== hdl/gss_ram.sv =====
module gss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 6144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/gss_update.sv =====
module gss_update #(
    parameter int FRAC_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gss_pkg::gss_sums_t  sums,
    input  gss_pkg::gss_coef_t  coef,
    output logic                out_valid,
    output logic signed [23:0]  new_u,
    output logic signed [23:0]  new_v
);
    import gss_pkg::*;

    localparam int LAP_W = 31;
    localparam int DP_W = LAP_W + 17;
    localparam int DQ_W = DP_W - 18;
    localparam int UV_W = 2 * CELL_W;
    localparam int UVS_W = UV_W - FRAC_BITS;
    localparam int RX_W = UVS_W + CELL_W;
    localparam int RE_W = RX_W - FRAC_BITS;
    localparam int OM_W = (FRAC_BITS + 2 > 26) ? FRAC_BITS + 2 : 26;
    localparam int PF_W = OM_W + 17;
    localparam int PFS_W = PF_W - 16;
    localparam int PL_W = 18 + CELL_W;
    localparam int PLS_W = PL_W - 16;
    localparam int M1_W = (RE_W > PFS_W) ? RE_W : PFS_W;
    localparam int SUM_W = ((M1_W > DQ_W) ? M1_W : DQ_W) + 3;
    localparam logic signed [OM_W-1:0] ONE = OM_W'(1) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) <<< (CELL_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SMIN = -(SUM_W'(1) <<< (CELL_W - 1));
    localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

    logic [4:0] vld_reg;

    // stage 1
    logic signed [LAP_W-1:0]  lap_u_reg, lap_v_reg;
    logic signed [CELL_W-1:0] u1_reg, v1_reg;
    // stage 2
    logic signed [DP_W-1:0]   pu_reg, pv_reg;
    logic signed [UV_W-1:0]   uv_reg;
    logic signed [PF_W-1:0]   pf_reg;
    logic signed [PL_W-1:0]   pl_reg;
    logic signed [CELL_W-1:0] u2_reg, v2_reg;
    // stage 3
    logic [DQ_W-1:0]          nu_reg, nv_reg;
    logic                     neg_u3_reg, neg_v3_reg;
    logic signed [RX_W-1:0]   rx_reg;
    logic signed [PFS_W-1:0]  feed3_reg;
    logic signed [PLS_W-1:0]  loss3_reg;
    logic signed [CELL_W-1:0] u3_reg, v3_reg;
    // stage 4
    logic [63:0]              mu_reg, mv_reg;
    logic                     neg_u4_reg, neg_v4_reg;
    logic signed [RE_W-1:0]   react_reg;
    logic signed [PFS_W-1:0]  feed4_reg;
    logic signed [PLS_W-1:0]  loss4_reg;
    logic signed [CELL_W-1:0] u4_reg, v4_reg;
    // stage 5
    logic signed [CELL_W-1:0] nu_out_reg, nv_out_reg;

    logic signed [LAP_W-1:0]  lap_u, lap_v, cu, cv;
    logic signed [OM_W-1:0]   one_minus_u;
    logic [16:0]              fk;
    logic signed [DQ_W-1:0]   dq_u, dq_v;
    logic [DQ_W-1:0]          tu, tv;
    logic signed [SUM_W-1:0]  du, dv, su, sv;

    always_comb
    begin
        cu = LAP_W'(sums.center_u);
        cv = LAP_W'(sums.center_v);
        lap_u = (LAP_W'(sums.edges_u) <<< 2) + LAP_W'(sums.corners_u)
              - (cu <<< 4) - (cu <<< 2);
        lap_v = (LAP_W'(sums.edges_v) <<< 2) + LAP_W'(sums.corners_v)
              - (cv <<< 4) - (cv <<< 2);
        one_minus_u = ONE - OM_W'(u1_reg);
        fk = {1'b0, coef.feed} + {1'b0, coef.kill};
        dq_u = $signed(pu_reg[DP_W-1:18]);
        dq_v = $signed(pv_reg[DP_W-1:18]);
        tu = mu_reg[34 +: DQ_W];
        tv = mv_reg[34 +: DQ_W];
        du = neg_u4_reg ? -SUM_W'($signed({1'b0, tu})) : SUM_W'($signed({1'b0, tu}));
        dv = neg_v4_reg ? -SUM_W'($signed({1'b0, tv})) : SUM_W'($signed({1'b0, tv}));
        su = SUM_W'(u4_reg) + du - SUM_W'(react_reg) + SUM_W'(feed4_reg);
        sv = SUM_W'(v4_reg) + dv + SUM_W'(react_reg) - SUM_W'(loss4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        lap_u_reg <= lap_u;
        lap_v_reg <= lap_v;
        u1_reg <= sums.center_u;
        v1_reg <= sums.center_v;

        pu_reg <= $signed({1'b0, coef.dif_u}) * lap_u_reg;
        pv_reg <= $signed({1'b0, coef.dif_v}) * lap_v_reg;
        uv_reg <= u1_reg * v1_reg;
        pf_reg <= $signed({1'b0, coef.feed}) * one_minus_u;
        pl_reg <= $signed({1'b0, fk}) * v1_reg;
        u2_reg <= u1_reg;
        v2_reg <= v1_reg;

        neg_u3_reg <= dq_u[DQ_W-1];
        neg_v3_reg <= dq_v[DQ_W-1];
        nu_reg <= dq_u[DQ_W-1] ? DQ_W'(DQ_W'(4) - dq_u) : DQ_W'(dq_u);
        nv_reg <= dq_v[DQ_W-1] ? DQ_W'(DQ_W'(4) - dq_v) : DQ_W'(dq_v);
        rx_reg <= $signed(uv_reg[UV_W-1:FRAC_BITS]) * v2_reg;
        feed3_reg <= $signed(pf_reg[PF_W-1:16]);
        loss3_reg <= $signed(pl_reg[PL_W-1:16]);
        u3_reg <= u2_reg;
        v3_reg <= v2_reg;

        mu_reg <= 64'(nu_reg) * 64'(RECIP5);
        mv_reg <= 64'(nv_reg) * 64'(RECIP5);
        neg_u4_reg <= neg_u3_reg;
        neg_v4_reg <= neg_v3_reg;
        react_reg <= $signed(rx_reg[RX_W-1:FRAC_BITS]);
        feed4_reg <= feed3_reg;
        loss4_reg <= loss3_reg;
        u4_reg <= u3_reg;
        v4_reg <= v3_reg;

        nu_out_reg <= (su > SMAX) ? CELL_W'(SMAX) : (su < SMIN) ? CELL_W'(SMIN) : CELL_W'(su);
        nv_out_reg <= (sv > SMAX) ? CELL_W'(SMAX) : (sv < SMIN) ? CELL_W'(SMIN) : CELL_W'(sv);
    end

    assign out_valid = vld_reg[4];
    assign new_u = nu_out_reg;
    assign new_v = nv_out_reg;

`ifndef SYNTH
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ($countones(vld_reg) == 0))
        else $error("update pipeline overlap");
    a_valid_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##5 out_valid)
        else $error("update result missing");
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(vld_reg[3]))
        else $error("stray update result");
`endif
endmodule

// ===== hdl/gray_scott_stencil_step_top.sv =====
// Gray-Scott reaction-diffusion stencil, one time step.
// cells: words (cell_u, cell_v, tile_start) in raster order, top halo row,
//   interior rows, bottom halo row; tile_start on a tile's first word.
// result: words (new_u, new_v, out_column, row_done). Once two rows are
//   held, each word of the next row updates the middle row: column c-1 for
//   c >= 2, and the row's last word also gives columns W-1 and 0 (row_done).
// Config: cfg_we/cfg_index/cfg_data write feed, kill, Du, Dv, row length.
// One word in flight at a time. cells.ready is high only when idle.
// A word that gives no result leaves the block idle. Each result costs 9 row
//   store reads on the single read port, a registered read, the update pipeline
//   and the output register, and waits there until result.ready; up to 3
//   results per word.
// The row store (3 x MAX_WIDTH entries) needs no clearing pass after reset.
// Reset clears counters and rotation and sets the config registers to their defaults.
// A stall on result holds the word in the output register and blocks cells.
module gray_scott_stencil_step_top #(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gss_cell_if.sink                          cells,
    gss_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gss_pkg::*;

    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam int COL_W = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        SEL_LO  = 2'd0,
        SEL_MID = 2'd1,
        SEL_HI  = 2'd2
    } sel_t;

    state_t state_reg, state_next;
    logic [RATE_W-1:0] feed_reg, kill_reg, dif_u_reg, dif_v_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [COL_W-1:0]  ccount_reg, ccount_next;
    logic [1:0]        rows_reg, rows_next;
    logic [1:0]        rot_reg, rot_next;
    logic [1:0]        erot_reg, erot_next;
    logic [COL_W-1:0]  ecol_reg [3];
    logic [COL_W-1:0]  ecol_next [3];
    logic [1:0]        en_reg, en_next;
    logic [1:0]        ei_reg, ei_next;
    logic              closes_reg, closes_next;
    sel_t              rr_reg, rr_next, rc_reg, rc_next;
    sel_t              dr_reg, dc_reg;
    logic              issued_reg, issued_next;
    logic              pend_reg;
    logic              go_reg;
    gss_sums_t         sums_reg, sums_next;
    logic signed [CELL_W-1:0] ou_reg, ov_reg;
    logic [OUT_COL_W-1:0]     ocol_reg;
    logic                     odone_reg;

    logic [LW-1:0]    rl, wx;
    logic [COL_W-1:0] wm1, cc, col, ec, lcol, rcol, rdcol;
    logic [1:0]       rs, rdslot;
    logic             acc, ram_re, upd_valid;
    logic [AW-1:0]    waddr, raddr;
    logic [47:0]      rdata;
    logic signed [CELL_W-1:0] rd_u, rd_v;
    logic signed [CELL_W-1:0] upd_u, upd_v;
    gss_coef_t        coef;

    function automatic logic [1:0] inc3(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] b;
        unique case (s)
            2'd0: b = '0;
            2'd1: b = AW'(MAX_WIDTH);
            2'd2: b = AW'(2 * MAX_WIDTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    always_comb
    begin
        rl = LW'(len_reg);
        if (rl < LW'(3))
            wx = LW'(3);
        else if (rl > LW'(MAX_WIDTH))
            wx = LW'(MAX_WIDTH);
        else
            wx = rl;
        wm1 = COL_W'(wx - LW'(1));
    end

    assign acc = cells.valid && cells.ready;
    assign cells.ready = (state_reg == ST_IDLE);
    assign cc = cells.tile_start ? '0 : ccount_reg;
    assign rs = cells.tile_start ? 2'd0 : rows_reg;
    assign col = (cc > wm1) ? wm1 : cc;
    assign waddr = slot_base(rot_reg) + AW'(col);

    assign ec = ecol_reg[ei_reg];
    assign lcol = (ec == '0) ? wm1 : ec - COL_W'(1);
    assign rcol = (ec == wm1) ? '0 : ec + COL_W'(1);

    always_comb
    begin
        unique case (rr_reg)
            SEL_LO:  rdslot = inc3(erot_reg);
            SEL_MID: rdslot = inc3(inc3(erot_reg));
            SEL_HI:  rdslot = erot_reg;
            default: rdslot = erot_reg;
        endcase
        unique case (rc_reg)
            SEL_LO:  rdcol = lcol;
            SEL_MID: rdcol = ec;
            SEL_HI:  rdcol = rcol;
            default: rdcol = ec;
        endcase
    end

    assign raddr = slot_base(rdslot) + AW'(rdcol);
    assign ram_re = (state_reg == ST_READ) && !issued_reg;
    assign rd_u = $signed(rdata[47:24]);
    assign rd_v = $signed(rdata[23:0]);

    gss_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (acc),
        .waddr (waddr),
        .wdata ({cells.cell_u, cells.cell_v}),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign coef = '{feed: feed_reg, kill: kill_reg, dif_u: dif_u_reg, dif_v: dif_v_reg};

    gss_update #(.FRAC_BITS(FRAC_BITS)) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (go_reg),
        .sums      (sums_reg),
        .coef      (coef),
        .out_valid (upd_valid),
        .new_u     (upd_u),
        .new_v     (upd_v)
    );

    always_comb
    begin
        state_next = state_reg;
        ccount_next = ccount_reg;
        rows_next = rows_reg;
        rot_next = rot_reg;
        erot_next = erot_reg;
        ecol_next = ecol_reg;
        en_next = en_reg;
        ei_next = ei_reg;
        closes_next = closes_reg;
        rr_next = rr_reg;
        rc_next = rc_reg;
        issued_next = issued_reg;
        sums_next = sums_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    en_next = 2'd0;
                    ei_next = 2'd0;
                    erot_next = rot_reg;
                    closes_next = (col == wm1);
                    if (rs == 2'd2)
                    begin
                        if (col >= COL_W'(2))
                        begin
                            ecol_next[0] = col - COL_W'(1);
                            en_next = 2'd1;
                        end
                        if (col == wm1)
                        begin
                            ecol_next[en_next] = wm1;
                            ecol_next[en_next + 2'd1] = '0;
                            en_next = en_next + 2'd2;
                        end
                    end
                    if (en_next != 2'd0)
                    begin
                        state_next = ST_READ;
                    end
                    rr_next = SEL_LO;
                    rc_next = SEL_LO;
                    issued_next = 1'b0;
                    sums_next = '0;
                    if (col == wm1)
                    begin
                        ccount_next = '0;
                        rot_next = inc3(rot_reg);
                        rows_next = (rs == 2'd2) ? rs : rs + 2'd1;
                    end
                    else
                    begin
                        ccount_next = col + COL_W'(1);
                        rows_next = rs;
                    end
                end
            end
            ST_READ:
            begin
                if (!issued_reg)
                begin
                    if (rc_reg == SEL_HI)
                    begin
                        rc_next = SEL_LO;
                        unique case (rr_reg)
                            SEL_LO:  rr_next = SEL_MID;
                            SEL_MID: rr_next = SEL_HI;
                            SEL_HI:  issued_next = 1'b1;
                            default: rr_next = SEL_LO;
                        endcase
                    end
                    else
                    begin
                        rc_next = (rc_reg == SEL_LO) ? SEL_MID : SEL_HI;
                    end
                end
                if (pend_reg)
                begin
                    if (dr_reg == SEL_MID && dc_reg == SEL_MID)
                    begin
                        sums_next.center_u = rd_u;
                        sums_next.center_v = rd_v;
                    end
                    else if (dr_reg == SEL_MID || dc_reg == SEL_MID)
                    begin
                        sums_next.edges_u = sums_reg.edges_u + SUM9_W'(rd_u);
                        sums_next.edges_v = sums_reg.edges_v + SUM9_W'(rd_v);
                    end
                    else
                    begin
                        sums_next.corners_u = sums_reg.corners_u + SUM9_W'(rd_u);
                        sums_next.corners_v = sums_reg.corners_v + SUM9_W'(rd_v);
                    end
                    if (issued_reg)
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (upd_valid)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    rr_next = SEL_LO;
                    rc_next = SEL_LO;
                    issued_next = 1'b0;
                    sums_next = '0;
                    if (ei_reg + 2'd1 < en_reg)
                    begin
                        ei_next = ei_reg + 2'd1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ccount_reg <= '0;
            rows_reg <= '0;
            rot_reg <= '0;
            erot_reg <= '0;
            en_reg <= '0;
            ei_reg <= '0;
            closes_reg <= 1'b0;
            rr_reg <= SEL_LO;
            rc_reg <= SEL_LO;
            dr_reg <= SEL_LO;
            dc_reg <= SEL_LO;
            issued_reg <= 1'b0;
            pend_reg <= 1'b0;
            go_reg <= 1'b0;
            feed_reg <= FEED_RST;
            kill_reg <= KILL_RST;
            dif_u_reg <= DIF_U_RST;
            dif_v_reg <= DIF_V_RST;
            len_reg <= LEN_RST;
        end
        else
        begin
            state_reg <= state_next;
            ccount_reg <= ccount_next;
            rows_reg <= rows_next;
            rot_reg <= rot_next;
            erot_reg <= erot_next;
            en_reg <= en_next;
            ei_reg <= ei_next;
            closes_reg <= closes_next;
            rr_reg <= rr_next;
            rc_reg <= rc_next;
            dr_reg <= rr_reg;
            dc_reg <= rc_reg;
            issued_reg <= issued_next;
            pend_reg <= ram_re;
            go_reg <= (state_reg == ST_READ) && pend_reg && issued_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FEED:  feed_reg <= cfg_data;
                    CFG_KILL:  kill_reg <= cfg_data;
                    CFG_DIF_U: dif_u_reg <= cfg_data;
                    CFG_DIF_V: dif_v_reg <= cfg_data;
                    CFG_LEN:   len_reg <= cfg_data[LEN_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ecol_reg <= ecol_next;
        sums_reg <= sums_next;
        if (state_reg == ST_CALC && upd_valid)
        begin
            ou_reg <= upd_u;
            ov_reg <= upd_v;
            ocol_reg <= OUT_COL_W'(ec);
            odone_reg <= closes_reg && (ei_reg + 2'd1 == en_reg);
        end
    end

    assign result.valid = (state_reg == ST_OUT);
    assign result.new_u = ou_reg;
    assign result.new_v = ov_reg;
    assign result.out_column = ocol_reg;
    assign result.row_done = odone_reg;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !cells.ready)
        else $error("input taken while result pending");
    a_calc_only: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid |-> (state_reg == ST_CALC))
        else $error("update result outside calc");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (en_reg != 2'd0 && ei_reg < en_reg))
        else $error("bad emit list");
    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != 2'd3)
        else $error("rows seen overflow");
`endif
endmodule

// ===== tb/gss_stencil_checker.sv =====
module gss_stencil_checker #(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 20
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cell_valid,
    input  logic  cell_ready,
    input  logic signed [23:0] cell_u,
    input  logic signed [23:0] cell_v,
    input  logic  cell_tile_start,
    input  logic  res_valid,
    input  logic  res_ready,
    input  logic signed [23:0] res_new_u,
    input  logic signed [23:0] res_new_v,
    input  logic [10:0] res_out_column,
    input  logic  res_row_done,
    input  logic  cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data,
    output int    fail_count,
    output int    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import gss_pkg::*;

    typedef struct {
        logic signed [23:0] new_u;
        logic signed [23:0] new_v;
        logic [10:0]        out_column;
        logic               row_done;
    } cell_update_t;

    cell_update_t updates_due[$];

    longint mem_u [3*MAX_WIDTH];
    longint mem_v [3*MAX_WIDTH];
    int unsigned col_cnt, full_rows, rot;
    logic [15:0] feed, kill, du_coef, dv_coef;
    logic [11:0] len;

    assign pending_count = updates_due.size();

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [23:0] clip24(longint x);
        if (x > 8388607)
            return 24'sh7FFFFF;
        if (x < -8388608)
            return 24'sh800000;
        return x[23:0];
    endfunction

    function automatic longint lap_u(int unsigned ra, int unsigned rm, int unsigned rb,
                                     int unsigned l, int unsigned c, int unsigned r);
        return 4 * (mem_u[rm+l] + mem_u[rm+r] + mem_u[ra+c] + mem_u[rb+c])
               + mem_u[ra+l] + mem_u[ra+r] + mem_u[rb+l] + mem_u[rb+r]
               - 20 * mem_u[rm+c];
    endfunction

    function automatic longint lap_v(int unsigned ra, int unsigned rm, int unsigned rb,
                                     int unsigned l, int unsigned c, int unsigned r);
        return 4 * (mem_v[rm+l] + mem_v[rm+r] + mem_v[ra+c] + mem_v[rb+c])
               + mem_v[ra+l] + mem_v[ra+r] + mem_v[rb+l] + mem_v[rb+r]
               - 20 * mem_v[rm+c];
    endfunction

    function automatic cell_update_t update_cell(int unsigned c, int unsigned w, logic done);
        cell_update_t e;
        int unsigned ra, rm, rb, l, r;
        longint one, u, v, dfu, dfv, uv, react, fd, loss;
        ra = ((rot + 1) % 3) * MAX_WIDTH;
        rm = ((rot + 2) % 3) * MAX_WIDTH;
        rb = (rot % 3) * MAX_WIDTH;
        l = (c == 0) ? w - 1 : c - 1;
        r = (c == w - 1) ? 0 : c + 1;
        one = longint'(1) << FRAC_BITS;
        u = mem_u[rm+c];
        v = mem_v[rm+c];
        dfu = fdiv(longint'(du_coef) * lap_u(ra, rm, rb, l, c, r), 20 * 65536);
        dfv = fdiv(longint'(dv_coef) * lap_v(ra, rm, rb, l, c, r), 20 * 65536);
        uv = fdiv(u * v, one);
        react = fdiv(uv * v, one);
        fd = fdiv(longint'(feed) * (one - u), 65536);
        loss = fdiv((longint'(feed) + longint'(kill)) * v, 65536);
        e.new_u = clip24(u + dfu - react + fd);
        e.new_v = clip24(v + dfv + react - loss);
        e.out_column = c[10:0];
        e.row_done = done;
        return e;
    endfunction

    task automatic accept_cell(logic signed [23:0] iu, logic signed [23:0] iv, logic ts);
        int unsigned w, c, slot;
        w = len;
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (ts)
        begin
            col_cnt = 0;
            full_rows = 0;
        end
        c = col_cnt;
        if (c > w - 1)
            c = w - 1;
        slot = (rot % 3) * MAX_WIDTH;
        mem_u[slot+c] = iu;
        mem_v[slot+c] = iv;
        if (full_rows >= 2)
        begin
            if (c >= 2)
                updates_due.push_back(update_cell(c - 1, w, 1'b0));
            if (c == w - 1)
            begin
                updates_due.push_back(update_cell(w - 1, w, 1'b0));
                updates_due.push_back(update_cell(0, w, 1'b1));
            end
        end
        if (c == w - 1)
        begin
            col_cnt = 0;
            rot = (rot + 1) % 3;
            if (full_rows < 2)
                full_rows++;
        end
        else
            col_cnt = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_update_t e;
        if (!rst_n)
        begin
            col_cnt = 0;
            full_rows = 0;
            rot = 0;
            feed = FEED_RST;
            kill = KILL_RST;
            du_coef = DIF_U_RST;
            dv_coef = DIF_V_RST;
            len = LEN_RST;
            updates_due.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FEED: feed = cfg_data;
                    CFG_KILL: kill = cfg_data;
                    CFG_DIF_U: du_coef = cfg_data;
                    CFG_DIF_V: dv_coef = cfg_data;
                    CFG_LEN: len = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                if (updates_due.size() == 0)
                begin
                    $error("unexpected result word, column %0d", res_out_column);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = updates_due.pop_front();
                    if (res_new_u !== e.new_u || res_new_v !== e.new_v
                        || res_out_column !== e.out_column || res_row_done !== e.row_done)
                    begin
                        if (res_new_u !== e.new_u)
                            $error("new_u: expected %0d, got %0d", e.new_u, res_new_u);
                        if (res_new_v !== e.new_v)
                            $error("new_v: expected %0d, got %0d", e.new_v, res_new_v);
                        if (res_out_column !== e.out_column)
                            $error("out_column: expected %0d, got %0d",
                                   e.out_column, res_out_column);
                        if (res_row_done !== e.row_done)
                            $error("row_done: expected %0d, got %0d", e.row_done, res_row_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cell_valid && cell_ready)
                accept_cell(cell_u, cell_v, cell_tile_start);
        end
    end
endmodule

// ===== tb/tb_gray_scott_stencil_step_top.sv =====
module tb_gray_scott_stencil_step_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gss_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count;
    int pending_count;
    int cycles;
    int hold_off;
    int unsigned cur_w;
    int unsigned words_sent;

    gss_cell_if cell_ch ();
    gss_result_if result_ch ();

    gray_scott_stencil_step_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cells(cell_ch.sink),
        .result(result_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    gss_stencil_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cell_valid(cell_ch.valid),
        .cell_ready(cell_ch.ready),
        .cell_u(cell_ch.cell_u),
        .cell_v(cell_ch.cell_v),
        .cell_tile_start(cell_ch.tile_start),
        .res_valid(result_ch.valid),
        .res_ready(result_ch.ready),
        .res_new_u(result_ch.new_u),
        .res_new_v(result_ch.new_v),
        .res_out_column(result_ch.out_column),
        .res_row_done(result_ch.row_done),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int mode;
        result_ch.ready = 1'b0;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                mode = (cycles / 300) % 3;
                if (mode == 0)
                    result_ch.ready <= 1'b1;
                else if (mode == 1)
                    result_ch.ready <= ($urandom_range(0, 3) != 0);
                else
                    result_ch.ready <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one word, after an optional gap with valid low; send_tile picks gaps at random between bursts
    task automatic send_word(logic signed [23:0] u, logic signed [23:0] v, logic ts,
                             int gap);
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.cell_u <= u;
        cell_ch.cell_v <= v;
        cell_ch.tile_start <= ts;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic signed [23:0] pick_value(int kind);
        case (kind)
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return $signed(24'($urandom_range(0, 1 << 21))) - 24'sd262144;
        endcase
    endfunction

    // tile: halo row, interior rows, halo row
    task automatic send_tile(int rows, int kind);
        int burst;
        int gap;
        burst = 0;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cur_w; c++)
            begin
                gap = 0;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                end
                burst--;
                send_word(pick_value($urandom_range(0, 9) < 8 ? 3 : kind),
                          pick_value($urandom_range(0, 9) < 8 ? 3 : kind),
                          (r == 0 && c == 0), gap);
            end
        cell_ch.valid <= 1'b0;
    endtask

    task automatic set_width(int w);
        write_reg(CFG_LEN, 12'(w));
        cur_w = (w < 3) ? 3 : w;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_u = '0;
        cell_ch.cell_v = '0;
        cell_ch.tile_start = 1'b0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: width 3, extreme values, extreme coefficients
        set_width(3);
        write_reg(CFG_FEED, 16'hFFFF);
        write_reg(CFG_KILL, 16'hFFFF);
        write_reg(CFG_DIF_U, 16'hFFFF);
        write_reg(CFG_DIF_V, 16'h0000);
        send_word(24'sh7FFFFF, 24'sh800000, 1'b1, 0);
        send_word(24'sh800000, 24'sh7FFFFF, 1'b0, 0);
        send_word(24'sh000000, 24'sh100000, 1'b0, 0);
        send_word(24'sh100000, 24'sh7FFFFF, 1'b0, 0);
        send_word(24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 0);
        send_word(24'sh800000, 24'sh800000, 1'b0, 0);
        send_word(24'sh555555, 24'shAAAAAA, 1'b0, 0);
        send_word(24'shAAAAAA, 24'sh555555, 1'b0, 0);
        send_word(24'sh0FFFFF, 24'sh000001, 1'b0, 0);
        send_word(24'shFFFFFF, 24'sh7FFFFF, 1'b0, 0);
        // tile restart mid-row
        send_word(24'sh080000, 24'sh040000, 1'b1, 0);
        cell_ch.valid <= 1'b0;
        drain();

        // clamped length 0, zero coefficients but Dv at its maximum
        write_reg(CFG_FEED, 16'h0000);
        write_reg(CFG_KILL, 16'h0000);
        write_reg(CFG_DIF_U, 16'h0000);
        write_reg(CFG_DIF_V, 16'hFFFF);
        set_width(0);
        send_tile(4, 0);
        drain();

        // long receiver hold-off while sending
        write_reg(CFG_FEED, FEED_RST);
        write_reg(CFG_KILL, KILL_RST);
        write_reg(CFG_DIF_U, DIF_U_RST);
        write_reg(CFG_DIF_V, DIF_V_RST);
        set_width(8);
        hold_off = 400;
        send_tile(5, 2);
        drain();

        // shrink mid-row: words past the end close the row
        set_width(6);
        send_word(24'sh010000, 24'sh020000, 1'b1, 0);
        for (int i = 0; i < 14; i++)
            send_word(pick_value(3), pick_value(3), 1'b0, 0);
        cell_ch.valid <= 1'b0;
        drain();
        set_width(3);
        for (int i = 0; i < 4; i++)
            send_word(pick_value(3), pick_value(3), 1'b0, 0);
        cell_ch.valid <= 1'b0;
        drain();

        // random tiles
        while (words_sent < 370)
        begin
            write_reg(CFG_FEED, 16'($urandom));
            write_reg(CFG_KILL, 16'($urandom));
            write_reg(CFG_DIF_U, 16'($urandom));
            write_reg(CFG_DIF_V, 16'($urandom));
            set_width($urandom_range(3, 12));
            send_tile($urandom_range(3, 6), $urandom_range(0, 2));
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
